// ===== rtl/mixing_hash_bucket_index_core_macros.svh =====
// assertion helpers for the bucket index core
`ifndef MIXING_HASH_BUCKET_INDEX_CORE_MACROS_SVH
`define MIXING_HASH_BUCKET_INDEX_CORE_MACROS_SVH
`ifndef SYNTH
`define MHBI_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MHBI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MHBI_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MHBI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/mhbi_pkg.sv =====
package mhbi_pkg;
   localparam int KeyWidth   = 64;
   localparam int CountWidth = 32;
   localparam int IndexWidth = 32;
   localparam int Rounds     = 3;
   localparam int ModStages  = KeyWidth;
   localparam int PipeDepth  = 1 + 2 * Rounds + ModStages;
   localparam int PreShift   = 4;

   localparam logic [KeyWidth-1:0] MixMul [Rounds] = '{
      64'hBF58476D1CE4E5B9, 64'h94D049BB133111EB, 64'h9E3779B97F4A7C15};
   localparam int MixShift [Rounds] = '{31, 30, 26};

   localparam logic [CountWidth-1:0] BucketCountReset = 32'd1024;
   localparam logic [31:0] IndexMask = (IndexWidth >= 32) ? 32'hFFFF_FFFF :
      32'((64'd1 << IndexWidth) - 64'd1);

   // register index, taken from byte address bit 2
   localparam logic RegBucketCount = 1'b0;
endpackage

// ===== rtl/mixing_hash_bucket_index_core.sv =====
// throughput: one request per cycle, busy is low except during reset
// stages: 1 pre-mix, 2 per multiply round (3 rounds), 64 one-bit remainder steps
// reset clears all valid bits and sets bucket_count to 1024
// the receiver cannot stall, results are shown for a single cycle
`include "mixing_hash_bucket_index_core_macros.svh"

module mixing_hash_bucket_index_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [mhbi_pkg::KeyWidth-1:0]     req_key,
   output logic                              rsp_strobe,
   output logic [31:0]                       rsp_bucket_index,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [2:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import mhbi_pkg::*;

   // request accept and valid chain
   logic                   accept;
   logic [PipeDepth-1:0]   vld_ff, vld_in;

   // configuration
   logic [CountWidth-1:0]  bucket_count_ff, bucket_count_in;
   logic                   csr_write;

   // pre-mix register
   logic [KeyWidth-1:0]    key_ff, key_in;

   // multiply rounds: partial products, then sum and xorshift
   logic [KeyWidth-1:0]    mix_src      [Rounds];
   logic [63:0]            mix_ll_ff    [Rounds];
   logic [63:0]            mix_ll_in    [Rounds];
   logic [31:0]            mix_hl_ff    [Rounds];
   logic [31:0]            mix_hl_in    [Rounds];
   logic [31:0]            mix_lh_ff    [Rounds];
   logic [31:0]            mix_lh_in    [Rounds];
   logic [KeyWidth-1:0]    mix_sum      [Rounds];
   logic [KeyWidth-1:0]    mix_b_ff     [Rounds];
   logic [KeyWidth-1:0]    mix_b_in     [Rounds];

   // restoring remainder, one dividend bit per stage
   logic [CountWidth-1:0]  rem_src      [ModStages];
   logic [KeyWidth-1:0]    div_src      [ModStages];
   logic [CountWidth:0]    rem_trial    [ModStages];
   logic [CountWidth-1:0]  rem_ff       [ModStages];
   logic [CountWidth-1:0]  rem_in       [ModStages];
   logic [KeyWidth-1:0]    div_ff       [ModStages];
   logic [KeyWidth-1:0]    div_in       [ModStages];

   // handshake: only reset holds requests off
   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      vld_in = {vld_ff[PipeDepth-2:0], accept};
   end

   // apb register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      bucket_count_in = bucket_count_ff;
      if (csr_write && csr_paddr[2] == RegBucketCount) begin
         bucket_count_in = csr_pwdata;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == RegBucketCount) begin
         csr_prdata = bucket_count_ff;
      end
   end

   // pre-mix
   assign key_in = req_key ^ (req_key >> PreShift);

   // mixing rounds: low 64 bits of x * c from three 32x32 partial products
   always_comb begin
      for (int r = 0; r < Rounds; r++) begin
         mix_src[r]   = (r == 0) ? key_ff : mix_b_ff[(r == 0) ? 0 : r - 1];
         mix_ll_in[r] = mix_src[r][31:0] * MixMul[r][31:0];
         mix_hl_in[r] = 32'(mix_src[r][63:32] * MixMul[r][31:0]);
         mix_lh_in[r] = 32'(mix_src[r][31:0] * MixMul[r][63:32]);
         mix_sum[r]   = mix_ll_ff[r] + {mix_hl_ff[r] + mix_lh_ff[r], 32'b0};
         mix_b_in[r]  = mix_sum[r] ^ (mix_sum[r] >> MixShift[r]);
      end
   end

   // remainder steps, dividend shifted out msb first
   always_comb begin
      for (int k = 0; k < ModStages; k++) begin
         rem_src[k]   = (k == 0) ? '0 : rem_ff[(k == 0) ? 0 : k - 1];
         div_src[k]   = (k == 0) ? mix_b_ff[Rounds-1] : div_ff[(k == 0) ? 0 : k - 1];
         rem_trial[k] = {rem_src[k], div_src[k][KeyWidth-1]};
         if (rem_trial[k] >= {1'b0, bucket_count_ff}) begin
            rem_in[k] = CountWidth'(rem_trial[k] - {1'b0, bucket_count_ff});
         end else begin
            rem_in[k] = CountWidth'(rem_trial[k]);
         end
         div_in[k]    = div_src[k] << 1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff          <= '0;
         bucket_count_ff <= BucketCountReset;
      end else begin
         vld_ff          <= vld_in;
         bucket_count_ff <= bucket_count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      for (int r = 0; r < Rounds; r++) begin
         mix_ll_ff[r] <= mix_ll_in[r];
         mix_hl_ff[r] <= mix_hl_in[r];
         mix_lh_ff[r] <= mix_lh_in[r];
         mix_b_ff[r]  <= mix_b_in[r];
      end
      for (int k = 0; k < ModStages; k++) begin
         rem_ff[k] <= rem_in[k];
         div_ff[k] <= div_in[k];
      end
   end

   // result, zero modulus gives index zero
   assign rsp_strobe       = vld_ff[PipeDepth-1];
   assign rsp_bucket_index = (bucket_count_ff == '0) ? '0 :
      (rem_ff[ModStages-1] & IndexMask);

   `MHBI_ASSERT_NEXT(a_enter, clock, reset, accept, vld_ff[0])
   `MHBI_ASSERT_IMPLIES(a_latency, clock, reset, rsp_strobe, $past(accept, PipeDepth))
   `MHBI_ASSERT_IMPLIES(a_zero_mod, clock, reset, rsp_strobe && bucket_count_ff == '0, rsp_bucket_index == '0)
   `MHBI_ASSERT_IMPLIES(a_in_range, clock, reset, rsp_strobe && bucket_count_ff != '0, rsp_bucket_index < bucket_count_ff)

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import mhbi_pkg::*;

   localparam int LatencyCycles = 71;
   localparam int DrainCycles   = LatencyCycles + 20;

   // addresses: register i at byte 4*i, paddr is 3 bits wide
   localparam logic [2:0] AddrBucketCount = 3'd0;
   localparam logic [2:0] AddrUnused      = 3'd4;

   // mixing multipliers and shifts, kept local to the predictor
   localparam logic [63:0] KMul1 = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] KMul2 = 64'h94D049BB133111EB;
   localparam logic [63:0] KMul3 = 64'h9E3779B97F4A7C15;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_key;
   logic        rsp_strobe;
   logic [31:0] rsp_bucket_index;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // pending keys, and the bucket indexes still owed by the block
   logic [63:0] key_queue[$];
   logic [31:0] index_queue[$];
   logic [31:0] model_bucket_count;
   int          fail_count;
   int          idle_left;
   bit          allow_idle;
   bit          hold_sender;

   mixing_hash_bucket_index_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_key          (req_key),
      .rsp_strobe       (rsp_strobe),
      .rsp_bucket_index (rsp_bucket_index),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // splitmix style mix then reduction, zero modulus gives zero
   function automatic logic [31:0] predict_index(input logic [63:0] key,
                                                 input logic [31:0] count);
      logic [63:0] x;
      x = key ^ (key >> 4);
      x = x * KMul1;
      x = x ^ (x >> 31);
      x = x * KMul2;
      x = x ^ (x >> 30);
      x = x * KMul3;
      x = x ^ (x >> 26);
      if (count == 32'd0) return 32'd0;
      return 32'(x % {32'd0, count}) & IndexMask;
   endfunction

   // driver: one key per accepted request, random idle bursts
   always @(posedge clock) begin
      if (reset) begin
         start   <= 1'b0;
         req_key <= '0;
         idle_left = 0;
      end else begin
         if (start && !busy) begin
            index_queue.push_back(predict_index(req_key, model_bucket_count));
         end
         if (start && busy) begin
            // request still waiting, keep it on the port
         end else if (hold_sender || key_queue.size() == 0) begin
            start <= 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (allow_idle && $urandom_range(0, 5) == 0) begin
            idle_left = $urandom_range(0, 2);
            start <= 1'b0;
         end else begin
            start   <= 1'b1;
            req_key <= key_queue.pop_front();
         end
      end
   end

   // monitor: every strobe must match the oldest owed index
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (index_queue.size() == 0) begin
            $error("bucket_index: unexpected result %0h", rsp_bucket_index);
            fail_count++;
         end else begin
            logic [31:0] want;
            want = index_queue.pop_front();
            if (rsp_bucket_index !== want) begin
               $error("bucket_index: expected %0h actual %0h", want, rsp_bucket_index);
               fail_count++;
            end
         end
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == AddrBucketCount) model_bucket_count = value;
   endtask

   // wait until no key is pending or owed, then idle for DrainCycles more clocks
   task automatic drain_block();
      int guard;
      guard = 0;
      while ((key_queue.size() != 0 || start || index_queue.size() != 0)
             && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic push_random_keys(input int count);
      logic [63:0] k;
      repeat (count) begin
         case ($urandom_range(0, 5))
            0: k = {60'd0, 4'($urandom)};
            1: k = {~60'd0, 4'($urandom)};
            default: k = {$urandom, $urandom};
         endcase
         key_queue.push_back(k);
      end
   endtask

   initial begin
      logic [31:0] counts[8];
      fail_count  = 0;
      allow_idle  = 1'b1;
      hold_sender = 1'b0;
      model_bucket_count = BucketCountReset;
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed keys at the reset bucket count
      key_queue.push_back(64'd0);
      key_queue.push_back(64'hFFFF_FFFF_FFFF_FFFF);
      key_queue.push_back(64'd1);
      key_queue.push_back(64'h8000_0000_0000_0000);
      key_queue.push_back(64'hAAAA_AAAA_AAAA_AAAA);
      key_queue.push_back(64'h5555_5555_5555_5555);
      key_queue.push_back(64'h0000_0000_FFFF_FFFF);
      key_queue.push_back(64'hFFFF_FFFF_0000_0000);
      drain_block();

      // write to an unused register index is ignored
      csr_write(AddrUnused, 32'd7);
      key_queue.push_back(64'h1234_5678_9ABC_DEF0);
      key_queue.push_back(64'hFEDC_BA98_7654_3210);
      drain_block();

      // zero modulus
      csr_write(AddrBucketCount, 32'd0);
      key_queue.push_back(64'd0);
      key_queue.push_back(64'hFFFF_FFFF_FFFF_FFFF);
      key_queue.push_back(64'hDEAD_BEEF_CAFE_F00D);
      drain_block();

      // bucket count sweep, extremes included
      counts = '{32'd1, 32'hFFFF_FFFF, 32'd2, 32'h8000_0000,
                 32'd1024, 32'd7, $urandom, 32'(1 + $urandom_range(0, 999))};
      foreach (counts[i]) begin
         csr_write(AddrBucketCount, counts[i]);
         push_random_keys(180);
         if (i == 3) begin
            // let requests fill the pipe, then hold off until every owed index has come back
            repeat (40) @(posedge clock);
            hold_sender = 1'b1;
            while (index_queue.size() != 0 || start) @(posedge clock);
            hold_sender = 1'b0;
         end
         if (i == 7) allow_idle = 1'b0;
         drain_block();
      end

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
